/* design/iba_pkg.sv */
// shared types and constants for the indexed block allocator
// no dependencies; imported by iba_counters and indexed_block_allocator_top
`default_nettype none

package iba_pkg;

    localparam int NUM_BLOCKS_DEF = 64;
    localparam int MAX_FILES_DEF  = 10;

    localparam int LENGTH_W = 6;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIR_FULL = 2'd3;

    // update commands from the allocation sequencer to the counters
    typedef struct packed {
        logic commit;  // a new file takes its directory slot
        logic claim;   // one block moves from free to used
    } iba_cnt_cmd_t;

endpackage

`default_nettype wire

/* design/iba_counters.sv */
// free-block and file counters with the admission checks for a request
// depends on iba_pkg
`default_nettype none

module iba_counters #(
    parameter int NUM_BLOCKS = iba_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_FILES  = iba_pkg::MAX_FILES_DEF,
    parameter int SLOT_W     = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire iba_pkg::iba_cnt_cmd_t         cmd,
    input  wire logic [iba_pkg::LENGTH_W-1:0]  length,
    output logic      [iba_pkg::STATUS_W-1:0]  chk_status,
    output logic      [SLOT_W-1:0]             chk_slot
);
    import iba_pkg::*;

    localparam int FCNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int FT_W   = $clog2(MAX_FILES + 1);
    localparam int NEED_W = LENGTH_W + 1;
    localparam int CMP_W  = (FCNT_W > NEED_W) ? FCNT_W : NEED_W;

    logic [FCNT_W-1:0] free_count_reg, free_count_next;
    logic [FT_W-1:0]   file_total_reg, file_total_next;
    logic [CMP_W-1:0]  free_ext;
    logic [CMP_W-1:0]  need_ext;

    always_comb
    begin
        free_ext = CMP_W'(free_count_reg);
        need_ext = CMP_W'(length) + CMP_W'(1);

        // first failing check wins
        if (free_count_reg == '0)
        begin
            chk_status = ST_NO_INDEX;
        end
        else if (free_ext < need_ext)
        begin
            chk_status = ST_NO_SPACE;
        end
        else if (file_total_reg >= FT_W'(MAX_FILES))
        begin
            chk_status = ST_DIR_FULL;
        end
        else
        begin
            chk_status = ST_OK;
        end

        chk_slot = SLOT_W'(file_total_reg);

        free_count_next = free_count_reg - FCNT_W'(cmd.claim);
        file_total_next = file_total_reg + FT_W'(cmd.commit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg <= FCNT_W'(NUM_BLOCKS);
            file_total_reg <= '0;
        end
        else
        begin
            free_count_reg <= free_count_next;
            file_total_reg <= file_total_next;
        end
    end

endmodule

`default_nettype wire

/* design/indexed_block_allocator_top.sv */
// indexed block allocator: first-fit scan of a used-block bitmap held in memory
// results: a refused request gives its single result in the cycle after acceptance;
//   an accepted one gives its index block once a registered read finds it free
// scan: one bitmap entry per cycle through the memory's single read port unless a
//   free entry waits on rsp_stall; one request at a time
// reset: a clearing pass writes every bitmap entry to zero, req_stall high
// depends on iba_pkg and iba_counters
`default_nettype none

module indexed_block_allocator_top #(
    parameter int NUM_BLOCKS = iba_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_FILES  = iba_pkg::MAX_FILES_DEF,
    parameter int BLK_W      = $clog2(NUM_BLOCKS),
    parameter int SLOT_W     = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [iba_pkg::LENGTH_W-1:0]  length,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic      [iba_pkg::STATUS_W-1:0]  status,
    output logic      [BLK_W-1:0]              block_number,
    output logic                               is_index,
    output logic      [SLOT_W-1:0]             file_slot,
    output logic                               last
);
    import iba_pkg::*;

    localparam int REM_W = LENGTH_W + 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [BLK_W-1:0]    addr_reg, addr_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic                first_reg, first_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BLK_W-1:0]    block_reg, block_next;
    logic                index_reg, index_next;
    logic [SLOT_W-1:0]   fslot_reg, fslot_next;
    logic                last_reg, last_next;

    logic                mem [NUM_BLOCKS];
    logic                mem_we;
    logic [BLK_W-1:0]    mem_waddr;
    logic                mem_wdata;
    logic                mem_re;
    logic [BLK_W-1:0]    mem_raddr;
    logic                rd_data_reg;

    iba_cnt_cmd_t        cnt_cmd;
    logic [STATUS_W-1:0] chk_status;
    logic [SLOT_W-1:0]   chk_slot;
    logic                can_emit;
    logic                req_fire;

    iba_counters #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .MAX_FILES  (MAX_FILES),
        .SLOT_W     (SLOT_W)
    ) u_counters (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cnt_cmd),
        .length     (length),
        .chk_status (chk_status),
        .chk_slot   (chk_slot)
    );

    always_comb
    begin
        can_emit  = !rsp_valid_reg || !rsp_stall;
        req_stall = !((state_reg == S_IDLE) && can_emit);
        req_fire  = req_valid && !req_stall;

        state_next     = state_reg;
        addr_next      = addr_reg;
        rem_next       = rem_reg;
        first_next     = first_reg;
        slot_next      = slot_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        status_next    = status_reg;
        block_next     = block_reg;
        index_next     = index_reg;
        fslot_next     = fslot_reg;
        last_next      = last_reg;

        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = addr_reg + BLK_W'(1);
        cnt_cmd        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (addr_reg == BLK_W'(NUM_BLOCKS - 1))
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + BLK_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (chk_status != ST_OK)
                    begin
                        rsp_valid_next = 1'b1;
                        status_next    = chk_status;
                        block_next     = '0;
                        index_next     = 1'b0;
                        fslot_next     = '0;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        cnt_cmd.commit = 1'b1;
                        slot_next      = chk_slot;
                        rem_next       = REM_W'(length) + REM_W'(1);
                        first_next     = 1'b1;
                        addr_next      = '0;
                        mem_re         = 1'b1;
                        mem_raddr      = '0;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_data_reg)
                begin
                    // used entry, skip it
                    addr_next = addr_reg + BLK_W'(1);
                    mem_re    = 1'b1;
                end
                else if (can_emit)
                begin
                    mem_we         = 1'b1;
                    mem_wdata      = 1'b1;
                    cnt_cmd.claim  = 1'b1;
                    rsp_valid_next = 1'b1;
                    status_next    = ST_OK;
                    block_next     = addr_reg;
                    index_next     = first_reg;
                    fslot_next     = slot_reg;
                    last_next      = (rem_reg == REM_W'(1));
                    first_next     = 1'b0;
                    rem_next       = rem_reg - REM_W'(1);
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        addr_next = addr_reg + BLK_W'(1);
                        mem_re    = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        first_reg  <= first_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        block_reg  <= block_next;
        index_reg  <= index_next;
        fslot_reg  <= fslot_next;
        last_reg   <= last_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign block_number = block_reg;
    assign is_index     = index_reg;
    assign file_slot    = fslot_reg;
    assign last         = last_reg;

`ifndef NO_ASSERTIONS
    // a refused request is a single closing transaction with no block
    a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status != ST_OK)) |-> (last && (block_number == '0) && !is_index))
        else $error("refused request result malformed");

    // a block is only claimed when the bitmap shows it free
    a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_wdata) |-> ((state_reg == S_SCAN) && !rd_data_reg))
        else $error("claimed a block that is already used");

    // the scan never runs with nothing left to claim
    a_scan_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (rem_reg != '0))
        else $error("scan active with zero blocks remaining");
`endif

endmodule

`default_nettype wire
